/* src/bpa_pkg.sv */
// Shared types, constants and helpers of the bitmap page allocator.
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;

    localparam int PAGE_W       = 15;     // register and window page width
    localparam int PAGE_OUT_W   = 14;     // page field width
    localparam int COUNT_OUT_W  = 15;     // free count field width
    localparam int OP_W         = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int MAX_PAGES_DEF = 16384;

    localparam logic [PAGE_W-1:0] TOTAL_RST = 15'd16384;
    localparam logic [PAGE_W-1:0] FIRST_RST = 15'd0;
    localparam logic [PAGE_W-1:0] LOWB_RST  = 15'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWB  = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 3'd0,
        OP_RANGE = 3'd1,
        OP_LOW   = 3'd2,
        OP_HIGH  = 3'd3,
        OP_ANY   = 3'd4,
        OP_FREE  = 3'd5
    } t_opcode;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_INIT  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_FREE  = 5'b10000
    } t_state;

    // Result of examining one bitmap byte against a window.
    typedef struct packed {
        logic       hit;
        logic [2:0] idx;    // bit position from the MSB, i.e. page offset in byte
        logic [7:0] mask;   // pages of the byte inside the window, MSB first
    } t_pick;

    typedef struct packed {
        logic              ok;
        logic [PAGE_W-1:0] ws;
        logic [PAGE_W-1:0] we;  // end clamped to the total
    } t_win;

    function automatic t_win win_check(logic [PAGE_W-1:0] ws, logic [PAGE_W-1:0] we_raw,
                                       logic [PAGE_W-1:0] tot, logic [PAGE_W-1:0] ff,
                                       logic cnt_nz);
        t_win w;
        w.ws = ws;
        w.we = (we_raw > tot) ? tot : we_raw;
        w.ok = cnt_nz && (ws < w.we) && (ws >= ff);
        return w;
    endfunction

endpackage
`default_nettype wire

/* src/bpa_ram.sv */
// Bitmap byte memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bpa_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* src/bpa_byte_pick.sv */
// Window mask and lowest-free-page pick within one bitmap byte.
`timescale 1ns / 1ps
`default_nettype none
module bpa_byte_pick #(
    parameter int AW = 11
) (
    input  wire logic [AW-1:0]                 i_byte,
    input  wire logic [7:0]                    i_data,
    input  wire logic [bpa_pkg::PAGE_W-1:0]    i_start,
    input  wire logic [bpa_pkg::PAGE_W-1:0]    i_end,
    output bpa_pkg::t_pick                     o_pick
);

    localparam int CW = (AW + 3 > bpa_pkg::PAGE_W) ? AW + 3 : bpa_pkg::PAGE_W;

    logic [CW-1:0] start_w;
    logic [CW-1:0] end_w;
    logic [CW-1:0] page_w;
    logic [7:0]    mask;
    logic [7:0]    avail;
    logic          found;
    logic [2:0]    idx;

    assign start_w = CW'(i_start);
    assign end_w   = CW'(i_end);

    always_comb begin
        mask  = '0;
        found = 1'b0;
        idx   = '0;
        page_w = '0;
        for (int j = 0; j < 8; j++) begin
            page_w = CW'({i_byte, 3'(j)});
            mask[7-j] = (page_w >= start_w) && (page_w < end_w);
        end
        avail = mask & i_data;
        // lowest page first, which is the most significant bit
        for (int j = 7; j >= 0; j--) begin
            if (avail[7-j]) begin
                found = 1'b1;
                idx   = 3'(j);
            end
        end
    end

    assign o_pick.hit  = found;
    assign o_pick.idx  = idx;
    assign o_pick.mask = mask;

endmodule
`default_nettype wire

/* src/bitmap_page_allocator.sv */
// Bitmap page-frame allocator top level: registers, sequencer and result port.
//
// Requests enter on start/busy: a request is taken at a clock edge with start
// high and busy low, carrying i_opcode, i_start_page, i_end_page, i_free_page.
// Each request gives one result on o_ok, o_page, o_free_count, shown for one
// cycle with o_valid high; the receiver cannot stall, so nothing waits on it.
// Configuration (total, first free page, low boundary) is written through
// i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data, always ready.
// Steps from the accepting edge to o_valid:
//   rejected request (bad window, page out of range, undefined op): result registered from idle
//   free: read, then modify and write back the bitmap byte
//   alloc: scans bitmap bytes, one byte per cycle through the
//     single read port; alloc-any may scan the high window, then the low one
//   init: writes all bitmap bytes (MAX_PAGES/8, 2048 by default), one byte
//     written per cycle
// One request is in flight at a time; busy drops in the cycle its result is
// shown, so the next request may enter then.
// After reset the block clears the bitmap memory, one byte per cycle,
// with busy high; configuration writes are still taken.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_allocator #(
    parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [bpa_pkg::OP_W-1:0]          i_opcode,
    input  wire logic [bpa_pkg::PAGE_W-1:0]        i_start_page,
    input  wire logic [bpa_pkg::PAGE_W-1:0]        i_end_page,
    input  wire logic [bpa_pkg::PAGE_OUT_W-1:0]    i_free_page,
    output logic                                   o_valid,
    output logic                                   o_ok,
    output logic [bpa_pkg::PAGE_OUT_W-1:0]         o_page,
    output logic [bpa_pkg::COUNT_OUT_W-1:0]        o_free_count,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bpa_pkg::PAGE_W-1:0]        i_cfg_data
);

    localparam int PW    = bpa_pkg::PAGE_W;
    localparam int DEPTH = (MAX_PAGES + 7) / 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(MAX_PAGES + 1);
    localparam logic [AW-1:0] LastByte   = AW'(DEPTH - 1);
    localparam logic [31:0]   MaxPages32 = 32'(MAX_PAGES);
    localparam logic [NW-1:0] MaxCount   = NW'(MAX_PAGES);

    bpa_pkg::t_state r_state, n_state;
    logic [PW-1:0]   r_total, r_ff, r_lowb;
    logic [PW-1:0]   r_ws, n_ws, r_we, n_we;
    logic [AW-1:0]   r_byte, n_byte, r_last, n_last;
    logic            r_second, n_second;
    logic [bpa_pkg::PAGE_OUT_W-1:0] r_fp, n_fp;
    logic [NW-1:0]   r_count, n_count;
    logic            r_valid, n_valid, r_ok, n_ok;
    logic [bpa_pkg::PAGE_OUT_W-1:0] r_page, n_page;

    logic [PW-1:0]   tot;
    logic            cnt_nz;
    bpa_pkg::t_win   win_a, win_b;
    logic [PW-1:0]   a_lastp, b_lastp;
    logic [PW-1:0]   fp_w;
    logic            fp_in;
    logic [7:0]      fp_mask;

    logic            mem_we;
    logic [7:0]      mem_wdata, mem_rdata;
    logic [AW-1:0]   mem_raddr;
    bpa_pkg::t_pick  pick;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= bpa_pkg::TOTAL_RST;
            r_ff    <= bpa_pkg::FIRST_RST;
            r_lowb  <= bpa_pkg::LOWB_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bpa_pkg::REG_TOTAL: r_total <= i_cfg_data;
                bpa_pkg::REG_FIRST: r_ff    <= i_cfg_data;
                bpa_pkg::REG_LOWB:  r_lowb  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign tot = (32'(r_total) > MaxPages32) ? MaxPages32[PW-1:0] : r_total;
    assign cnt_nz = (r_count != '0);

    // primary window of the request, and the low window that alloc-any falls back to
    always_comb begin
        case (bpa_pkg::t_opcode'(i_opcode))
            bpa_pkg::OP_RANGE: win_a = bpa_pkg::win_check(i_start_page, i_end_page,
                                                          tot, r_ff, cnt_nz);
            bpa_pkg::OP_LOW:   win_a = bpa_pkg::win_check(r_ff, r_lowb, tot, r_ff, cnt_nz);
            default:           win_a = bpa_pkg::win_check(r_lowb, tot, tot, r_ff, cnt_nz);
        endcase
        win_b = bpa_pkg::win_check(r_ff, r_lowb, tot, r_ff, cnt_nz);
    end

    assign a_lastp = win_a.we - PW'(1);
    assign b_lastp = win_b.we - PW'(1);

    assign fp_w    = PW'(i_free_page);
    assign fp_in   = (fp_w >= r_ff) && (fp_w < tot);
    assign fp_mask = 8'h80 >> r_fp[2:0];

    bpa_byte_pick #(
        .AW(AW)
    ) u_pick (
        .i_byte  (r_byte),
        .i_data  (mem_rdata),
        .i_start (r_ws),
        .i_end   (r_we),
        .o_pick  (pick)
    );

    bpa_ram #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_byte),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_ws      = r_ws;
        n_we      = r_we;
        n_byte    = r_byte;
        n_last    = r_last;
        n_second  = r_second;
        n_fp      = r_fp;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_ok      = 1'b0;
        n_page    = '0;
        mem_we    = 1'b0;
        mem_wdata = '0;
        mem_raddr = r_byte;

        unique case (r_state)
            bpa_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                n_byte = r_byte + AW'(1);
                if (r_byte == LastByte) begin
                    n_byte  = '0;
                    n_state = bpa_pkg::S_IDLE;
                end
            end

            bpa_pkg::S_IDLE: begin
                if (start) begin
                    n_valid = 1'b1;   // dropped below when the request needs memory
                    unique case (bpa_pkg::t_opcode'(i_opcode)) inside
                        bpa_pkg::OP_INIT: begin
                            n_valid = 1'b0;
                            n_ws    = r_ff;
                            n_we    = tot;
                            n_byte  = '0;
                            n_count = (tot > r_ff) ? NW'(tot - r_ff) : '0;
                            n_state = bpa_pkg::S_INIT;
                        end
                        bpa_pkg::OP_RANGE, bpa_pkg::OP_LOW,
                        bpa_pkg::OP_HIGH, bpa_pkg::OP_ANY: begin
                            if (win_a.ok) begin
                                n_valid   = 1'b0;
                                n_ws      = win_a.ws;
                                n_we      = win_a.we;
                                n_byte    = AW'(win_a.ws[PW-1:3]);
                                n_last    = AW'(a_lastp[PW-1:3]);
                                n_second  = (i_opcode == bpa_pkg::OP_ANY);
                                mem_raddr = AW'(win_a.ws[PW-1:3]);
                                n_state   = bpa_pkg::S_SCAN;
                            end else if (i_opcode == bpa_pkg::OP_ANY && win_b.ok) begin
                                n_valid   = 1'b0;
                                n_ws      = win_b.ws;
                                n_we      = win_b.we;
                                n_byte    = AW'(win_b.ws[PW-1:3]);
                                n_last    = AW'(b_lastp[PW-1:3]);
                                n_second  = 1'b0;
                                mem_raddr = AW'(win_b.ws[PW-1:3]);
                                n_state   = bpa_pkg::S_SCAN;
                            end
                        end
                        bpa_pkg::OP_FREE: begin
                            if (fp_in) begin
                                n_valid   = 1'b0;
                                n_fp      = i_free_page;
                                n_byte    = AW'(i_free_page[bpa_pkg::PAGE_OUT_W-1:3]);
                                mem_raddr = AW'(i_free_page[bpa_pkg::PAGE_OUT_W-1:3]);
                                n_state   = bpa_pkg::S_FREE;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            bpa_pkg::S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = pick.mask;
                n_byte    = r_byte + AW'(1);
                if (r_byte == LastByte) begin
                    n_valid = 1'b1;
                    n_ok    = 1'b1;
                    n_state = bpa_pkg::S_IDLE;
                end
            end

            bpa_pkg::S_SCAN: begin
                if (pick.hit) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata & ~(8'h80 >> pick.idx);
                    n_count   = r_count - NW'(1);
                    n_valid   = 1'b1;
                    n_ok      = 1'b1;
                    n_page    = bpa_pkg::PAGE_OUT_W'({r_byte, pick.idx});
                    n_state   = bpa_pkg::S_IDLE;
                end else if (r_byte == r_last) begin
                    if (r_second && win_b.ok) begin
                        // high window exhausted, fall back to low memory
                        n_ws      = win_b.ws;
                        n_we      = win_b.we;
                        n_byte    = AW'(win_b.ws[PW-1:3]);
                        n_last    = AW'(b_lastp[PW-1:3]);
                        n_second  = 1'b0;
                        mem_raddr = AW'(win_b.ws[PW-1:3]);
                    end else begin
                        n_valid = 1'b1;
                        n_state = bpa_pkg::S_IDLE;
                    end
                end else begin
                    mem_raddr = r_byte + AW'(1);
                    n_byte    = r_byte + AW'(1);
                end
            end

            bpa_pkg::S_FREE: begin
                if ((mem_rdata & fp_mask) == 8'h00) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata | fp_mask;
                    if (r_count < MaxCount) begin
                        n_count = r_count + NW'(1);
                    end
                end
                n_valid = 1'b1;
                n_ok    = 1'b1;
                n_page  = r_fp;
                n_state = bpa_pkg::S_IDLE;
            end

            default: n_state = bpa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bpa_pkg::S_CLEAR;
            r_byte   <= '0;
            r_second <= 1'b0;
            r_count  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_byte   <= n_byte;
            r_second <= n_second;
            r_count  <= n_count;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ws   <= n_ws;
        r_we   <= n_we;
        r_last <= n_last;
        r_fp   <= n_fp;
        r_ok   <= n_ok;
        r_page <= n_page;
    end

    assign busy         = (r_state != bpa_pkg::S_IDLE);
    assign o_valid      = r_valid;
    assign o_ok         = r_ok;
    assign o_page       = r_page;
    assign o_free_count = bpa_pkg::COUNT_OUT_W'(r_count);

endmodule
`default_nettype wire

/* verif/bitmap_page_allocator_checker.sv */
// Checker for the bitmap page allocator: mirrors the page map, predicts each result and compares.
`timescale 1ns / 1ps
module bitmap_page_allocator_checker
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic                   i_busy,
    input  wire logic [OP_W-1:0]        i_opcode,
    input  wire logic [PAGE_W-1:0]      i_start_page,
    input  wire logic [PAGE_W-1:0]      i_end_page,
    input  wire logic [PAGE_OUT_W-1:0]  i_free_page,
    input  wire logic                   i_valid,
    input  wire logic                   i_ok,
    input  wire logic [PAGE_OUT_W-1:0]  i_page,
    input  wire logic [COUNT_OUT_W-1:0] i_free_count,
    input  wire logic                   i_cfg_valid,
    input  wire logic                   i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [PAGE_W-1:0]      i_cfg_data,
    output int                          o_fail_count,
    output int                          o_outstanding
);

    typedef struct packed {
        logic                   ok;
        logic [PAGE_OUT_W-1:0]  page;
        logic [COUNT_OUT_W-1:0] free_count;
    } t_alloc_result;

    bit            page_free [MAX_PAGES];
    int            free_total;
    int            total_reg;
    int            first_reg;
    int            lowb_reg;
    t_alloc_result awaited_results [$];
    t_alloc_result want;
    int            fails = 0;
    int            queued = 0;

    assign o_fail_count  = fails;
    assign o_outstanding = queued;

    function automatic int usable_total();
        return (total_reg > MAX_PAGES) ? MAX_PAGES : total_reg;
    endfunction

    // Take the lowest free page of [ws, we); the end is clamped to the total.
    function automatic bit take_lowest_free(int ws, int we, output int got);
        int tot;
        tot = usable_total();
        got = 0;
        if (free_total == 0)
            return 1'b0;
        if (we > tot)
            we = tot;
        if (ws >= we || ws < first_reg)
            return 1'b0;
        for (int p = ws; p < we; p++) begin
            if (page_free[p]) begin
                page_free[p] = 1'b0;
                free_total--;
                got = p;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_alloc_result apply_request(logic [OP_W-1:0] op, int sp, int ep, int fp);
        t_alloc_result r;
        bit            ok;
        int            got;
        int            tot;
        tot = usable_total();
        ok  = 1'b0;
        got = 0;
        case (op)
            OP_INIT: begin
                foreach (page_free[p])
                    page_free[p] = 1'b0;
                free_total = 0;
                for (int p = first_reg; p < tot; p++) begin
                    page_free[p] = 1'b1;
                    free_total++;
                end
                ok = 1'b1;
            end
            OP_RANGE: ok = take_lowest_free(sp, ep, got);
            OP_LOW:   ok = take_lowest_free(first_reg, lowb_reg, got);
            OP_HIGH:  ok = take_lowest_free(lowb_reg, tot, got);
            OP_ANY: begin
                ok = take_lowest_free(lowb_reg, tot, got);
                if (!ok)
                    ok = take_lowest_free(first_reg, lowb_reg, got);
            end
            OP_FREE: begin
                if (fp >= first_reg && fp < tot) begin
                    // count a page only when it was in use
                    if (!page_free[fp]) begin
                        page_free[fp] = 1'b1;
                        if (free_total < MAX_PAGES)
                            free_total++;
                    end
                    got = fp;
                    ok  = 1'b1;
                end
            end
            default: ;
        endcase
        if (!ok)
            got = 0;
        r.ok         = ok;
        r.page       = got[PAGE_OUT_W-1:0];
        r.free_count = free_total[COUNT_OUT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            total_reg  = TOTAL_RST;
            first_reg  = FIRST_RST;
            lowb_reg   = LOWB_RST;
            free_total = 0;
            foreach (page_free[p])
                page_free[p] = 1'b0;
            awaited_results.delete();
            queued <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_TOTAL: total_reg = i_cfg_data;
                    REG_FIRST: first_reg = i_cfg_data;
                    REG_LOWB:  lowb_reg  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                awaited_results.push_back(apply_request(i_opcode, i_start_page, i_end_page,
                                                        i_free_page));
            if (i_valid) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no request pending: ok=%0d page=%0d free_count=%0d",
                           i_ok, i_page, i_free_count);
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_ok !== want.ok) begin
                        $error("ok mismatch: expected %0d, got %0d", want.ok, i_ok);
                        fails++;
                    end
                    if (i_page !== want.page) begin
                        $error("page mismatch: expected %0d, got %0d", want.page, i_page);
                        fails++;
                    end
                    if (i_free_count !== want.free_count) begin
                        $error("free_count mismatch: expected %0d, got %0d",
                               want.free_count, i_free_count);
                        fails++;
                    end
                end
            end
            queued <= awaited_results.size();
        end
    end

endmodule

/* verif/bitmap_page_allocator_tb.sv */
// Top of the bitmap page allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module bitmap_page_allocator_tb;
    import bpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 50;
    localparam int RAND_PHASES    = 14;
    localparam int PHASE_ITEMS    = 19;
    localparam int QUIET_PHASES   = 3;
    localparam int PAGE_LIMIT     = MAX_PAGES_DEF;
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   start        = 1'b0;
    logic [OP_W-1:0]        i_opcode     = OP_INIT;
    logic [PAGE_W-1:0]      i_start_page = '0;
    logic [PAGE_W-1:0]      i_end_page   = '0;
    logic [PAGE_OUT_W-1:0]  i_free_page  = '0;
    logic                   i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index  = REG_TOTAL;
    logic [PAGE_W-1:0]      i_cfg_data   = '0;
    logic                   busy;
    logic                   o_valid;
    logic                   o_ok;
    logic [PAGE_OUT_W-1:0]  o_page;
    logic [COUNT_OUT_W-1:0] o_free_count;
    logic                   o_cfg_ready;
    int                     fail_count;
    int                     outstanding;

    bit idle_en = 1'b1;
    int cur_total = TOTAL_RST;
    int cur_first = FIRST_RST;

    always #5 i_clk = ~i_clk;

    bitmap_page_allocator uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_start_page (i_start_page),
        .i_end_page   (i_end_page),
        .i_free_page  (i_free_page),
        .o_valid      (o_valid),
        .o_ok         (o_ok),
        .o_page       (o_page),
        .o_free_count (o_free_count),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    bitmap_page_allocator_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_opcode      (i_opcode),
        .i_start_page  (i_start_page),
        .i_end_page    (i_end_page),
        .i_free_page   (i_free_page),
        .i_valid       (o_valid),
        .i_ok          (o_ok),
        .i_page        (o_page),
        .i_free_count  (o_free_count),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[PAGE_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_TOTAL: cur_total = value;
            REG_FIRST: cur_first = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_limits(int tot, int ff, int lowb);
        cfg_write(REG_TOTAL, tot);
        cfg_write(REG_FIRST, ff);
        cfg_write(REG_LOWB, lowb);
    endtask

    // Hold start high until the request is taken, sometimes with a random gap ahead of it.
    task automatic issue(logic [OP_W-1:0] op, int sp, int ep, int fp);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_start_page <= sp[PAGE_W-1:0];
        i_end_page   <= ep[PAGE_W-1:0];
        i_free_page  <= fp[PAGE_OUT_W-1:0];
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic pick_limits(int phase);
        int shape;
        int tot;
        int ff;
        int lowb;
        shape = (phase < 2) ? phase : $urandom_range(0, 9);
        case (shape)
            0: begin
                tot  = PAGE_LIMIT;
                ff   = $urandom_range(0, 64);
                lowb = $urandom_range(ff, PAGE_LIMIT);
            end
            1: begin
                tot  = 0;
                ff   = 0;
                lowb = $urandom_range(0, 64);
            end
            2: begin
                tot  = $urandom_range(8, 64);
                ff   = $urandom_range(tot, tot + 50);
                lowb = $urandom_range(0, tot);
            end
            3: begin
                tot  = $urandom_range(16, 200);
                ff   = $urandom_range(8, tot);
                lowb = $urandom_range(0, ff);
            end
            4: begin
                tot  = $urandom_range(8, 200);
                ff   = $urandom_range(0, tot / 2);
                lowb = $urandom_range(tot, PAGE_LIMIT);
            end
            5: begin
                tot  = $urandom_range(8, 300);
                ff   = 0;
                lowb = 0;
            end
            default: begin
                tot  = $urandom_range(8, 256);
                ff   = $urandom_range(0, tot / 4);
                lowb = $urandom_range(ff, tot);
            end
        endcase
        // leave a register at its old value now and then
        if (phase < 2 || $urandom_range(0, 4) != 0)
            cfg_write(REG_TOTAL, tot);
        if (phase < 2 || $urandom_range(0, 4) != 0)
            cfg_write(REG_FIRST, ff);
        if (phase < 2 || $urandom_range(0, 4) != 0)
            cfg_write(REG_LOWB, lowb);
    endtask

    task automatic random_request();
        int               r;
        int               sp;
        int               ep;
        int               fp;
        int               hi;
        logic [OP_W-1:0]  op;
        r  = $urandom_range(0, 99);
        sp = $urandom_range(0, PAGE_LIMIT);
        ep = $urandom_range(0, PAGE_LIMIT);
        fp = $urandom_range(0, PAGE_LIMIT - 1);
        if (r < 3)
            op = OP_INIT;
        else if (r < 5)
            op = $urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO;
        else if (r < 20)
            op = OP_RANGE;
        else if (r < 30)
            op = OP_LOW;
        else if (r < 40)
            op = OP_HIGH;
        else if (r < 60)
            op = OP_ANY;
        else
            op = OP_FREE;
        if (op == OP_RANGE && $urandom_range(0, 3) != 0) begin
            sp = $urandom_range(cur_first, cur_total);
            ep = sp + $urandom_range(0, 40);
            if (sp > PAGE_LIMIT)
                sp = PAGE_LIMIT;
            if (ep > PAGE_LIMIT)
                ep = PAGE_LIMIT;
        end
        if (op == OP_FREE && $urandom_range(0, 4) != 0) begin
            hi = (cur_total > 0) ? cur_total - 1 : 0;
            fp = $urandom_range(cur_first, hi);
            if (fp > PAGE_LIMIT - 1)
                fp = PAGE_LIMIT - 1;
        end
        issue(op, sp, ep, fp);
    endtask

    // End the run when nothing moves on any channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("bitmap_page_allocator_tb failed");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_limits(64, 8, 32);
        issue(OP_ANY, 0, 0, 0);                         // nothing free before init
        issue(OP_UNDEF_LO, 0, 0, 0);
        issue(OP_UNDEF_HI, PAGE_LIMIT, PAGE_LIMIT, PAGE_LIMIT - 1);
        issue(OP_INIT, 0, 0, 0);
        issue(OP_LOW, 0, 0, 0);
        issue(OP_HIGH, 0, 0, 0);
        issue(OP_ANY, 0, 0, 0);
        issue(OP_RANGE, 8, 16, 0);
        issue(OP_RANGE, 0, 20, 0);                      // start below first free page
        issue(OP_RANGE, 20, 20, 0);                     // empty window
        issue(OP_RANGE, 60, PAGE_LIMIT, 0);             // end clamped to the total
        issue(OP_RANGE, PAGE_LIMIT, PAGE_LIMIT, 0);
        issue(OP_FREE, 0, 0, 3);                        // below first free page
        issue(OP_FREE, 0, 0, 64);                       // at the total
        issue(OP_FREE, 0, 0, PAGE_LIMIT - 1);
        issue(OP_FREE, 0, 0, 40);                       // already free
        issue(OP_FREE, 0, 0, 8);
        issue(OP_FREE, 0, 0, 0);
        drain();

        // run the pool dry: high window first, then low, then failure
        set_limits(16, 12, 14);
        issue(OP_INIT, 0, 0, 0);
        repeat (5) issue(OP_ANY, 0, 0, 0);
        drain();

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase >= RAND_PHASES - QUIET_PHASES)
                idle_en = 1'b0;
            pick_limits(phase);
            if (phase < 2 || $urandom_range(0, 6) != 0)
                issue(OP_INIT, 0, 0, 0);
            repeat (PHASE_ITEMS) random_request();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("bitmap_page_allocator_tb passed");
        else
            $display("bitmap_page_allocator_tb failed");
        $finish;
    end

endmodule
